[rtl/adcvc_pkg.sv]
// shared types and constants of the adc voltage two-point calibrator
package adcvc_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CHAN_W   = 6;
   localparam int unsigned GAIN_W   = 24;
   localparam int unsigned REF_W    = 12;
   localparam int unsigned DEVT_W   = 17;
   localparam int unsigned DEN_W    = 17;
   localparam int unsigned QUO_W    = 28;
   localparam int unsigned PROD_W   = 41;

   localparam logic [1:0] REG_CAL_ENABLE  = 2'd0;
   localparam logic [1:0] REG_VOLT_GAIN   = 2'd1;
   localparam logic [1:0] REG_REF_VOLTAGE = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CAL    = 1'b1;

   localparam logic signed [DEVT_W-1:0] FAULT_LIMIT = -17'sd100;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd143207;
   localparam logic [REF_W-1:0]  REF_RESET  = 12'd1100;

   // one result in flight through the divider stages
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic                       cal;
      logic                       fault;
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] volt;
      logic                       neg;
      logic [DEN_W-1:0]           den;
      logic [QUO_W-1:0]           work;
      logic [DEN_W-1:0]           rem;
   } div_stage_type;

   // one restoring division step: dividend bits leave work at the top,
   // quotient bits enter at the bottom
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type     r;
      logic [DEN_W:0]    sh;
      logic [DEN_W:0]    diff;
      logic              take;
      r    = s;
      sh   = {s.rem, s.work[QUO_W-1]};
      diff = sh - {1'b0, s.den};
      take = (sh >= {1'b0, s.den});
      r.rem  = take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      r.work = {s.work[QUO_W-2:0], take};
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(logic signed [QUO_W+1:0] x);
      logic signed [SAMPLE_W-1:0] r;
      if (x > 30'sd32767) begin
         r = 16'sh7fff;
      end else if (x < -30'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/adc_voltage_two_point_calibrator_unit.sv]
// adc voltage two-point calibrator: two channels per word, q20 scaling, calibration divide
// path: each result passes through the holding register, 3 front stages, numerator stage,
// 28 divider stages and the output register; the high result follows its low result
// throughput: a sample item issues a low then a high slot (one calibration memory read
// per channel), a load a single slot; one result per cycle while the output is not stalled
// reset: synchronous, active high; clears control state and loads register defaults;
// the calibration memory is not cleared and must be loaded before it is read
module adc_voltage_two_point_calibrator_unit
   import adcvc_pkg::*;
#(
   parameter int unsigned USED_CHANNELS = 40,
   parameter int unsigned CAL_DEPTH     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // word_index[4:0], sample_word[36:5], cal_channel[42:37], cal_low[58:43],
   // cal_high[74:59], zero fill
   input  logic [79:0] req_tdata,
   // kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // channel[5:0], voltage[21:6], cal_fault[22], zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int unsigned AW        = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
   localparam int unsigned DIV_STEPS = QUO_W;

   // configuration registers
   logic              cal_enable_ff;
   logic [GAIN_W-1:0] volt_gain_ff;
   logic [REF_W-1:0]  ref_voltage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_enable_ff  <= 1'b1;
         volt_gain_ff   <= GAIN_RESET;
         ref_voltage_ff <= REF_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CAL_ENABLE:  cal_enable_ff  <= csr_wdata[0];
            REG_VOLT_GAIN:   volt_gain_ff   <= csr_wdata[GAIN_W-1:0];
            REG_REF_VOLTAGE: ref_voltage_ff <= csr_wdata[REF_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register can take a result
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_tready;

   // holding register: a sample item is issued as a low slot then a high slot
   logic        h_valid_ff, h_phase_ff;
   logic        h_kind_ff;
   logic [4:0]  h_idx_ff;
   logic [31:0] h_word_ff;
   logic [CHAN_W-1:0]   h_cch_ff;
   logic [2*SAMPLE_W-1:0] h_entry_ff;

   logic issue, slot_done, accept, issue_load;
   assign issue      = adv && h_valid_ff;
   assign slot_done  = (h_kind_ff == KIND_CAL) || h_phase_ff;
   assign req_tready = adv && (!h_valid_ff || slot_done);
   assign accept     = req_tvalid && req_tready;
   assign issue_load = issue && (h_kind_ff == KIND_CAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         h_phase_ff <= 1'b0;
      end else if (accept) begin
         h_valid_ff <= 1'b1;
         h_phase_ff <= 1'b0;
      end else if (issue) begin
         h_valid_ff <= !slot_done;
         h_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         h_kind_ff  <= req_tuser;
         h_idx_ff   <= req_tdata[4:0];
         h_word_ff  <= req_tdata[36:5];
         h_cch_ff   <= req_tdata[42:37];
         h_entry_ff <= {req_tdata[74:59], req_tdata[58:43]};
      end
   end

   // channel mapping of the current slot
   logic [CHAN_W-1:0] lo_ch, hi_ch, slot_ch;
   logic              lo_keep, hi_keep, slot_keep, slot_last;
   logic [SAMPLE_W-1:0] slot_raw;
   assign lo_ch   = {h_idx_ff[4:3], 1'b0, h_idx_ff[2:0]};
   assign hi_ch   = {h_idx_ff[4:3], 1'b1, ~h_idx_ff[2:0]};
   assign lo_keep = (32'(lo_ch) < USED_CHANNELS);
   assign hi_keep = (32'(hi_ch) < USED_CHANNELS);

   always_comb begin
      if (h_kind_ff == KIND_CAL) begin
         slot_ch   = h_cch_ff;
         slot_raw  = h_word_ff[SAMPLE_W-1:0];
         slot_keep = 1'b0;
         slot_last = 1'b0;
      end else if (h_phase_ff) begin
         slot_ch   = hi_ch;
         slot_raw  = h_word_ff[31:16];
         slot_keep = hi_keep;
         slot_last = 1'b1;
      end else begin
         slot_ch   = lo_ch;
         slot_raw  = h_word_ff[15:0];
         slot_keep = lo_keep;
         slot_last = !hi_keep;
      end
   end

   // calibration memory, one write or one read per slot, in slot order
   logic [AW+CHAN_W-1:0]  ch_ext;
   logic [AW-1:0]         mem_addr;
   logic                  in_depth;
   logic [2*SAMPLE_W-1:0] cal_mem [CAL_DEPTH];
   logic [2*SAMPLE_W-1:0] rd_ff;

   assign ch_ext   = (AW+CHAN_W)'(slot_ch);
   assign mem_addr = ch_ext[AW-1:0];
   assign in_depth = (32'(slot_ch) < CAL_DEPTH);

   always_ff @(posedge clock) begin
      if (issue_load && in_depth) begin
         cal_mem[mem_addr] <= h_entry_ff;
      end
      if (adv) begin
         rd_ff <= cal_mem[mem_addr];
      end
   end

   // stage 1: slot registered alongside the memory read
   logic                       s1_valid_ff, s1_last_ff, s1_depth_ff;
   logic [CHAN_W-1:0]          s1_ch_ff;
   logic signed [SAMPLE_W-1:0] s1_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue && slot_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff  <= slot_last;
         s1_depth_ff <= in_depth;
         s1_ch_ff    <= slot_ch;
         s1_raw_ff   <= slot_raw;
      end
   end

   // stage 2: q20 gain product
   logic                       s2_valid_ff, s2_last_ff;
   logic [CHAN_W-1:0]          s2_ch_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic [2*SAMPLE_W-1:0]      s2_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff  <= s1_last_ff;
         s2_ch_ff    <= s1_ch_ff;
         s2_prod_ff  <= PROD_W'(s1_raw_ff * $signed({1'b0, volt_gain_ff}));
         s2_entry_ff <= s1_depth_ff ? rd_ff : '0;
      end
   end

   // stage 3: truncate toward zero, saturate, deviation and fault check
   logic [PROD_W-1:0]          p_mag;
   logic [PROD_W-21:0]         p_shift;
   logic signed [SAMPLE_W-1:0] v_sat;
   logic signed [SAMPLE_W-1:0] e_lo, e_hi;
   logic signed [DEVT_W-1:0]   devt;
   logic signed [DEVT_W:0]     den;
   logic                       fault;

   assign p_mag   = s2_prod_ff[PROD_W-1] ? PROD_W'(-s2_prod_ff) : s2_prod_ff;
   assign p_shift = p_mag[PROD_W-1:20];
   always_comb begin
      if (p_shift > (PROD_W-20)'(s2_prod_ff[PROD_W-1] ? 32768 : 32767)) begin
         v_sat = s2_prod_ff[PROD_W-1] ? 16'sh8000 : 16'sh7fff;
      end else begin
         v_sat = s2_prod_ff[PROD_W-1] ? -$signed(p_shift[SAMPLE_W-1:0])
                                      : $signed(p_shift[SAMPLE_W-1:0]);
      end
   end
   assign e_lo  = s2_entry_ff[SAMPLE_W-1:0];
   assign e_hi  = s2_entry_ff[2*SAMPLE_W-1:SAMPLE_W];
   assign devt  = DEVT_W'(e_hi) - DEVT_W'(e_lo);
   assign den   = $signed({1'b0, (DEVT_W)'(ref_voltage_ff)}) + (DEVT_W+1)'(devt);
   assign fault = (devt <= FAULT_LIMIT) || (den <= 0);

   logic                       s3_valid_ff, s3_last_ff, s3_cal_ff, s3_fault_ff;
   logic [CHAN_W-1:0]          s3_ch_ff;
   logic signed [SAMPLE_W-1:0] s3_v_ff, s3_lo_ff;
   logic [DEN_W-1:0]           s3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff  <= s2_last_ff;
         s3_cal_ff   <= cal_enable_ff;
         s3_fault_ff <= cal_enable_ff && fault;
         s3_ch_ff    <= s2_ch_ff;
         s3_v_ff     <= v_sat;
         s3_lo_ff    <= e_lo;
         s3_den_ff   <= den[DEN_W-1:0];
      end
   end

   // stage 4: numerator v * ref, split into sign and magnitude
   logic signed [QUO_W:0] num;
   assign num = (QUO_W+1)'(s3_v_ff * $signed({1'b0, ref_voltage_ff}));

   div_stage_type div_ff [DIV_STEPS+1];
   div_stage_type div_in [DIV_STEPS+1];

   always_comb begin
      div_in[0].valid   = s3_valid_ff;
      div_in[0].last    = s3_last_ff;
      div_in[0].cal     = s3_cal_ff;
      div_in[0].fault   = s3_fault_ff;
      div_in[0].channel = s3_ch_ff;
      div_in[0].lo      = s3_lo_ff;
      div_in[0].volt    = s3_v_ff;
      div_in[0].neg     = num[QUO_W];
      div_in[0].den     = s3_den_ff;
      div_in[0].work    = num[QUO_W] ? QUO_W'(-num) : num[QUO_W-1:0];
      div_in[0].rem     = '0;
      for (int i = 1; i <= DIV_STEPS; i++) begin
         div_in[i] = div_step(div_ff[i-1]);
      end
   end

   // divider stages, one quotient bit each
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            div_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   // final correction: sign, bypass on fault, offset removal and saturation
   div_stage_type         fin;
   logic signed [QUO_W:0] quo;
   logic signed [QUO_W+1:0] corr;
   logic signed [SAMPLE_W-1:0] volt_out;

   assign fin  = div_ff[DIV_STEPS];
   assign quo  = fin.fault ? (QUO_W+1)'(fin.volt)
               : (fin.neg ? -$signed({1'b0, fin.work}) : $signed({1'b0, fin.work}));
   assign corr = (QUO_W+2)'(quo) - (QUO_W+2)'(fin.lo);
   assign volt_out = fin.cal ? sat16(corr) : fin.volt;

   logic [CHAN_W-1:0]   rsp_ch_ff;
   logic [SAMPLE_W-1:0] rsp_volt_ff;
   logic                rsp_fault_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ch_ff    <= fin.channel;
         rsp_volt_ff  <= volt_out;
         rsp_fault_ff <= fin.fault;
         rsp_last_ff  <= fin.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fault_ff, rsp_volt_ff, rsp_ch_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // only kept channels reach the output
   a_used_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[5:0]) < USED_CHANNELS))
      else $error("result for unused channel");

   // a calibration load produces no pipeline slot
   a_load_no_slot: assert property (@(posedge clock) disable iff (reset)
      issue_load |=> !s1_valid_ff)
      else $error("calibration load entered the pipeline");

   // new item only when the holding register is free or finishing
   a_hold_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!h_valid_ff || (issue && slot_done)))
      else $error("holding register overwritten");

   // second slot exists only for sample items
   a_phase_sample: assert property (@(posedge clock) disable iff (reset)
      (h_valid_ff && h_phase_ff) |-> (h_kind_ff == KIND_SAMPLE))
      else $error("high slot on calibration load");
`endif

endmodule

[sim/adc_voltage_two_point_calibrator_unit_test.sv]
// testbench of the adc voltage two-point calibrator: directed and random items, scoreboard check
module adc_voltage_two_point_calibrator_unit_test;
   import adcvc_pkg::*;

   localparam int unsigned N_CHAN    = 40;
   localparam int unsigned STORE_LEN = 64;

   // one predicted voltage result
   typedef struct {
      logic [5:0]         channel;
      logic signed [15:0] voltage;
      logic               cal_fault;
      logic               last;
   } volt_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [23:0] csr_wdata;

   adc_voltage_two_point_calibrator_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers and the calibration store
   logic        cal_on;
   logic [23:0] gain;
   logic [11:0] vref;
   logic [31:0] cal_mem [STORE_LEN];

   volt_result_t pending_volts[$];
   int  error_count;
   int  results_seen;
   int  faults_seen;
   int  items_sent;
   bit  hold_off;          // long receiver stall requested
   bit  burst_mode;        // sender gaps on/off

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("FAIL");
      $finish;
   end

   // saturate to int16
   function automatic logic signed [15:0] clamp16(longint x);
      if (x > 32767) return 16'sh7fff;
      if (x < -32768) return 16'sh8000;
      return x[15:0];
   endfunction

   // scale one raw code and apply the calibration of its channel
   function automatic volt_result_t predict_volt(int unsigned ch, logic signed [15:0] raw);
      volt_result_t r;
      longint p, v, lo, hi, devt, den, q;
      p = longint'(raw) * longint'(gain);
      if (p < 0) v = -((-p) >>> 20);
      else v = p >>> 20;
      v = clamp16(v);
      r.channel   = ch[5:0];
      r.cal_fault = 1'b0;
      r.last      = 1'b0;
      if (cal_on) begin
         lo   = $signed(cal_mem[ch][15:0]);
         hi   = $signed(cal_mem[ch][31:16]);
         devt = hi - lo;
         den  = longint'(vref) + devt;
         if (devt <= -100 || den <= 0) begin
            q = v;
            r.cal_fault = 1'b1;
         end else begin
            q = (v * longint'(vref)) / den;
         end
         v = clamp16(q - lo);
      end
      r.voltage = v[15:0];
      return r;
   endfunction

   // sender: one item, with an optional random gap before it
   task automatic send_item(logic kind, logic [4:0] widx, logic [31:0] word,
                            logic [5:0] cch, logic [15:0] clo, logic [15:0] chi);
      int unsigned base, lo_ch, hi_ch, n;
      volt_result_t lr, hr;
      if (burst_mode && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, chi, clo, cch, word, widx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == KIND_CAL) begin
         if (cch < STORE_LEN) begin
            cal_mem[cch] = {chi, clo};
         end
      end else begin
         base  = 16 * (widx >> 3);
         lo_ch = base + widx[2:0];
         hi_ch = base + 15 - widx[2:0];
         n = 0;
         if (lo_ch < N_CHAN) begin
            lr = predict_volt(lo_ch, word[15:0]);
            pending_volts.push_back(lr);
            n++;
         end
         if (hi_ch < N_CHAN) begin
            hr = predict_volt(hi_ch, word[31:16]);
            pending_volts.push_back(hr);
            n++;
         end
         if (n > 0) pending_volts[$].last = 1'b1;
      end
      // valid stays high so the next item can follow back to back
   endtask

   // wait until every expected result is back, then let the pipeline drain
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_volts.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_CAL_ENABLE:  cal_on = val[0];
         REG_VOLT_GAIN:   gain   = val;
         REG_REF_VOLTAGE: vref   = val[11:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random sample word for a word index whose channels are all loaded
   task automatic send_sample(logic [4:0] widx);
      logic [31:0] w;
      case ($urandom_range(0, 3))
         0: w = {$urandom_range(0, 1) ? 16'h7fff : 16'h8000,
                 $urandom_range(0, 1) ? 16'h8000 : 16'h7fff};
         1: w = {16'($urandom_range(0, 400)) - 16'd200, 16'($urandom_range(0, 400)) - 16'd200};
         default: w = $urandom;
      endcase
      send_item(KIND_SAMPLE, widx, w, 6'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic load_cal(logic [5:0] ch, logic signed [15:0] lo, logic signed [15:0] hi);
      send_item(KIND_CAL, 5'($urandom), $urandom, ch, lo, hi);
   endtask

   // random calibration entry: mostly small well-formed pairs, some faults and extremes
   task automatic load_random_cal(logic [5:0] ch);
      logic signed [15:0] lo, hi;
      case ($urandom_range(0, 5))
         0: begin lo = 16'($urandom); hi = 16'($urandom); end
         1: begin lo = 16'($urandom_range(0, 200)); hi = lo - 16'($urandom_range(95, 105)); end
         default: begin
            lo = 16'($urandom_range(0, 40)) - 16'sd20;
            hi = lo + 16'($urandom_range(0, 300)) - 16'sd90;
         end
      endcase
      load_cal(ch, lo, hi);
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      volt_result_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_volts.size() == 0) begin
            $error("result with no expectation: channel %0d", rsp_tdata[5:0]);
            error_count++;
         end else begin
            e = pending_volts.pop_front();
            if (e.cal_fault) faults_seen++;
            if (rsp_tdata[5:0] !== e.channel) begin
               $error("channel expected %0d actual %0d", e.channel, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[21:6] !== e.voltage) begin
               $error("voltage expected %0d actual %0d", e.voltage,
                      $signed(rsp_tdata[21:6]));
               error_count++;
            end
            if (rsp_tdata[22] !== e.cal_fault) begin
               $error("cal_fault expected %0b actual %0b", e.cal_fault, rsp_tdata[22]);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last expected %0b actual %0b", e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // receiver: phases of no stall, random stall, and the long hold-off
   initial begin
      int phase;
      int hold_count;
      rsp_tready <= 1'b0;
      phase = 0;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_count++;
            rsp_tready <= (hold_count > 300);
            if (hold_count > 300) hold_off = 1'b0;
         end else begin
            hold_count = 0;
            if ($urandom_range(0, 99) == 0) phase = $urandom_range(0, 2);
            case (phase)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   // load every used channel with a benign entry so reads stay defined
   task automatic test_cal_loads();
      for (int c = 0; c < N_CHAN; c++) load_cal(6'(c), 16'sd0, 16'sd0);
      load_cal(6'd63, 16'sh8000, 16'sh7fff);   // above the used channels, never reaches a result
      load_cal(6'd41, 16'sh7fff, 16'sh8000);
   endtask

   // field extremes, every even word index, fault and saturation corners
   task automatic test_directed();
      load_cal(6'd0, 16'sh8000, 16'sh7fff);          // large positive deviation
      load_cal(6'd15, 16'sd0, -16'sd100);            // deviation exactly at fault limit
      load_cal(6'd1, 16'sd0, -16'sd99);              // just above fault limit
      load_cal(6'd14, 16'sh7fff, 16'sh8000);         // deviation far below limit
      send_item(KIND_SAMPLE, 5'd0, 32'h7fff_8000, 6'd0, 16'd0, 16'd0);
      send_item(KIND_SAMPLE, 5'd1, 32'h8000_7fff, 6'd0, 16'd0, 16'd0);
      send_item(KIND_SAMPLE, 5'd0, 32'hffff_ffff, 6'h3f, 16'hffff, 16'hffff);
      send_item(KIND_SAMPLE, 5'd1, 32'h0000_0000, 6'd0, 16'd0, 16'd0);
      for (int k = 0; k < 32; k += 2) send_sample(5'(k));
      send_item(KIND_SAMPLE, 5'd31, 32'h1234_5678, 6'd0, 16'd0, 16'd0); // no result
      send_item(KIND_SAMPLE, 5'd24, $urandom, 6'd0, 16'd0, 16'd0);      // no result
   endtask

   // random traffic: loads mixed with samples under the current register setting
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 6) == 0) load_random_cal(6'($urandom_range(0, N_CHAN - 1)));
         else if ($urandom_range(0, 40) == 0) load_random_cal(6'($urandom_range(N_CHAN, 63)));
         else send_sample(5'($urandom));
      end
   endtask

   // block fills up while the receiver holds off
   task automatic test_backpressure();
      hold_off = 1'b1;
      test_random(80);
      drain();
   endtask

   task automatic test_config_sweep();
      write_reg(REG_CAL_ENABLE, 24'd0);
      write_reg(REG_VOLT_GAIN, 24'hffffff);
      test_random(60);
      drain();
      write_reg(REG_VOLT_GAIN, 24'd0);
      test_random(30);
      drain();
      write_reg(REG_CAL_ENABLE, 24'd1);
      write_reg(REG_REF_VOLTAGE, 24'd101);
      write_reg(REG_VOLT_GAIN, 24'($urandom));
      test_random(70);
      drain();
      write_reg(REG_REF_VOLTAGE, 24'd4095);
      write_reg(REG_VOLT_GAIN, 24'hffffff);
      test_random(70);
      drain();
      write_reg(REG_REF_VOLTAGE, 24'($urandom_range(101, 4095)));
      write_reg(REG_VOLT_GAIN, 24'd1 << 20);
      test_random(60);
      drain();
   endtask

   initial begin
      error_count  = 0;
      results_seen = 0;
      faults_seen  = 0;
      items_sent   = 0;
      hold_off     = 1'b0;
      burst_mode   = 1'b1;
      cal_on = 1'b1;
      gain   = GAIN_RESET;
      vref   = REF_RESET;
      for (int c = 0; c < STORE_LEN; c++) begin
         cal_mem[c] = 32'd0;
      end
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cal_loads();
      test_directed();
      drain();
      test_random(60);
      drain();                 // sender pauses until everything is back
      test_backpressure();
      test_config_sweep();

      $display("items sent %0d, results checked %0d, calibration faults %0d",
               items_sent, results_seen, faults_seen);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
